/* src/slcan_pkg.sv */
// Shared constants and helpers for the CAN frame to slcan text encoder.
package slcan_pkg;

   localparam int unsigned CHAR_W     = 7;
   localparam int unsigned TICK_W     = 32;
   localparam int unsigned TS_W       = 16;

   // Timestamp wraps modulo this count (59999)
   localparam logic [TS_W-1:0] TS_MODULUS = 16'hEA5F;

   localparam logic [CHAR_W-1:0] CH_CR     = 7'h0D;
   localparam logic [CHAR_W-1:0] CH_STD_DT = 7'h74;  // 't'
   localparam logic [CHAR_W-1:0] CH_STD_RT = 7'h72;  // 'r'
   localparam logic [CHAR_W-1:0] CH_EXT_DT = 7'h54;  // 'T'
   localparam logic [CHAR_W-1:0] CH_EXT_RT = 7'h52;  // 'R'
   localparam logic [CHAR_W-1:0] CH_ZERO   = 7'h30;  // '0'
   localparam logic [CHAR_W-1:0] CH_ALPHA  = 7'h37;  // 'A' - 10

   // Upper-case hex digit for one nibble
   function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
      logic [CHAR_W-1:0] base;
      base = (nib < 4'd10) ? CH_ZERO : CH_ALPHA;
      return base + {3'b000, nib};
   endfunction

endpackage

/* src/can_frame_to_slcan_ascii.sv */
// Top level: CAN frame to slcan (Lawicel) ASCII line encoder.
//
// Usage:
//  - req_* channel: one received CAN frame per transfer (valid/ready).
//    req_ready is high only while the sequencer is idle; one frame at a time.
//  - rsp_* channel: one ASCII character per transfer, rsp_is_last set on the
//    closing CR. Line: type letter, 3 or 8 id digits, DLC digit, 2 digits per
//    data byte, optional 4 timestamp digits, CR (6..27 characters, 10..31
//    with timestamp).
//  - csr_* channel: writes timestamp_enable; csr_ready is always high.
//    Write it only while no frame is in flight.
// Order of events, receiver always ready:
//  - After the accept the sequencer loads the first character into the
//    output register, then one per cycle; req_ready returns once the CR
//    is loaded.
//  - With timestamp, the tick modulo 59999 comes first from a folding unit
//    (at most seven multiply-add folds and a final subtract).
// Reset: synchronous; clears the sequencer, output valid and timestamp_enable.
// A stalled receiver freezes the sequencer; the held character stays put.
module can_frame_to_slcan_ascii (
   input  logic                              clock,
   input  logic                              reset,
   // frame input
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_is_extended,
   input  logic                              req_is_remote,
   input  logic [28:0]                       req_frame_id,
   input  logic [3:0]                        req_length_code,
   input  logic [63:0]                       req_payload,
   input  logic [slcan_pkg::TICK_W-1:0]      req_tick_count,
   // character output
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [slcan_pkg::CHAR_W-1:0]      rsp_ascii_char,
   output logic                              rsp_is_last,
   // register write
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic                              csr_timestamp_enable
);

   // Sequencer states
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MOD  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   // Line sections while emitting
   localparam logic [2:0] PH_TYPE = 3'd0;
   localparam logic [2:0] PH_ID   = 3'd1;
   localparam logic [2:0] PH_DLC  = 3'd2;
   localparam logic [2:0] PH_DATA = 3'd3;
   localparam logic [2:0] PH_TS   = 3'd4;
   localparam logic [2:0] PH_CR   = 3'd5;

   localparam logic [3:0] MAX_DLC = 4'd8;

   logic [1:0]                       state_ff, state_in;
   logic [2:0]                       phase_ff, phase_in;
   logic [3:0]                       cnt_ff, cnt_in;
   logic                             ts_en_ff, ts_en_in;
   logic                             ext_ff, ext_in;
   logic                             rtr_ff, rtr_in;
   logic [3:0]                       dlc_ff, dlc_in;
   logic [31:0]                      id_ff, id_in;
   logic [63:0]                      data_ff, data_in;
   logic [slcan_pkg::TS_W-1:0]       ts_ff, ts_in;
   logic                             out_valid_ff, out_valid_in;
   logic [slcan_pkg::CHAR_W-1:0]     out_char_ff, out_char_in;
   logic                             out_last_ff, out_last_in;

   logic                             req_xfer;
   logic                             advance;
   logic                             mod_done;
   logic [slcan_pkg::TS_W-1:0]       mod_rem;
   logic [slcan_pkg::CHAR_W-1:0]     cur_char;
   logic [4:0]                       data_last;
   logic [3:0]                       id_last;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid & req_ready;
   assign csr_ready = 1'b1;

   // Output register free or being drained this cycle
   assign advance   = (state_ff == ST_EMIT) & (~out_valid_ff | rsp_ready);

   assign id_last   = ext_ff ? 4'd7 : 4'd2;
   assign data_last = {dlc_ff, 1'b0} - 5'd1;

   slcan_tsmod u_tsmod (
      .clock     (clock),
      .reset     (reset),
      .start     (req_xfer & ts_en_ff),
      .dividend  (req_tick_count),
      .done      (mod_done),
      .remainder (mod_rem)
   );

   // Character for the current line position
   always_comb begin
      unique case (phase_ff)
         PH_TYPE: begin
            if (ext_ff) cur_char = rtr_ff ? slcan_pkg::CH_EXT_RT : slcan_pkg::CH_EXT_DT;
            else        cur_char = rtr_ff ? slcan_pkg::CH_STD_RT : slcan_pkg::CH_STD_DT;
         end
         PH_ID:   cur_char = slcan_pkg::hex_char(id_ff[31:28]);
         PH_DLC:  cur_char = slcan_pkg::hex_char(dlc_ff);
         PH_DATA: cur_char = slcan_pkg::hex_char(cnt_ff[0] ? data_ff[3:0] : data_ff[7:4]);
         PH_TS:   cur_char = slcan_pkg::hex_char(ts_ff[slcan_pkg::TS_W-1 -: 4]);
         default: cur_char = slcan_pkg::CH_CR;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      cnt_in       = cnt_ff;
      ts_en_in     = ts_en_ff;
      ext_in       = ext_ff;
      rtr_in       = rtr_ff;
      dlc_in       = dlc_ff;
      id_in        = id_ff;
      data_in      = data_ff;
      ts_in        = ts_ff;
      out_valid_in = out_valid_ff & ~rsp_ready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;

      if (csr_valid) ts_en_in = csr_timestamp_enable;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               ext_in   = req_is_extended;
               rtr_in   = req_is_remote;
               dlc_in   = (req_length_code > MAX_DLC) ? MAX_DLC : req_length_code;
               // Left-justify the id so the first digit is always the top nibble
               id_in    = req_is_extended ? {3'b000, req_frame_id}
                                          : {req_frame_id[11:0], 20'h00000};
               data_in  = req_payload;
               phase_in = PH_TYPE;
               cnt_in   = '0;
               state_in = ts_en_ff ? ST_MOD : ST_EMIT;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               ts_in    = mod_rem;
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (advance) begin
               out_valid_in = 1'b1;
               out_char_in  = cur_char;
               out_last_in  = (phase_ff == PH_CR);
               unique case (phase_ff)
                  PH_TYPE: begin
                     phase_in = PH_ID;
                     cnt_in   = '0;
                  end
                  PH_ID: begin
                     id_in  = {id_ff[27:0], 4'h0};
                     cnt_in = cnt_ff + 4'd1;
                     if (cnt_ff == id_last) phase_in = PH_DLC;
                  end
                  PH_DLC: begin
                     cnt_in = '0;
                     if (dlc_ff != 4'd0) phase_in = PH_DATA;
                     else                phase_in = ts_en_ff ? PH_TS : PH_CR;
                  end
                  PH_DATA: begin
                     // Low nibble done: move to the next byte
                     if (cnt_ff[0]) data_in = {8'h00, data_ff[63:8]};
                     cnt_in = cnt_ff + 4'd1;
                     if ({1'b0, cnt_ff} == data_last) begin
                        cnt_in   = '0;
                        phase_in = ts_en_ff ? PH_TS : PH_CR;
                     end
                  end
                  PH_TS: begin
                     ts_in  = {ts_ff[slcan_pkg::TS_W-5:0], 4'h0};
                     cnt_in = cnt_ff + 4'd1;
                     if (cnt_ff == 4'd3) phase_in = PH_CR;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_TYPE;
         cnt_ff       <= '0;
         ts_en_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         cnt_ff       <= cnt_in;
         ts_en_ff     <= ts_en_in;
         out_valid_ff <= out_valid_in;
      end
      ext_ff      <= ext_in;
      rtr_ff      <= rtr_in;
      dlc_ff      <= dlc_in;
      id_ff       <= id_in;
      data_ff     <= data_in;
      ts_ff       <= ts_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_ascii_char = out_char_ff;
   assign rsp_is_last    = out_last_ff;

endmodule

/* src/slcan_tsmod.sv */
// Iterative modulo unit: tick count modulo the timestamp wrap, by folding the high half.
module slcan_tsmod (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [slcan_pkg::TICK_W-1:0]   dividend,
   output logic                           done,
   output logic [slcan_pkg::TS_W-1:0]     remainder
);

   localparam int unsigned HI_W = slcan_pkg::TICK_W - slcan_pkg::TS_W;

   // 2^16 mod 59999: the high half folds onto the low half with this weight
   localparam logic [slcan_pkg::TS_W-1:0] FOLD_K =
      ~slcan_pkg::TS_MODULUS + {{(slcan_pkg::TS_W-1){1'b0}}, 1'b1};

   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;
   logic [slcan_pkg::TICK_W-1:0]  acc_ff, acc_in;
   logic [slcan_pkg::TS_W-1:0]    rem_ff, rem_in;
   logic [slcan_pkg::TICK_W-1:0]  fold;
   logic                          hi_zero;

   // One fold per cycle: hi * (2^16 mod M) + lo keeps the residue, shrinks the value.
   // At most seven folds bring any 32-bit value below 2^16.
   assign fold = {{slcan_pkg::TS_W{1'b0}}, acc_ff[slcan_pkg::TICK_W-1:slcan_pkg::TS_W]}
               * {{HI_W{1'b0}}, FOLD_K}
               + {{HI_W{1'b0}}, acc_ff[slcan_pkg::TS_W-1:0]};
   assign hi_zero = (acc_ff[slcan_pkg::TICK_W-1:slcan_pkg::TS_W] == '0);

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      acc_in  = acc_ff;
      rem_in  = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         acc_in  = dividend;
      end else if (busy_ff) begin
         if (!hi_zero) begin
            acc_in = fold;
         end else begin
            // below 2^16 < 2*M: one conditional subtract finishes it
            busy_in = 1'b0;
            done_in = 1'b1;
            rem_in  = (acc_ff[slcan_pkg::TS_W-1:0] >= slcan_pkg::TS_MODULUS)
                    ? acc_ff[slcan_pkg::TS_W-1:0] - slcan_pkg::TS_MODULUS
                    : acc_ff[slcan_pkg::TS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;

endmodule

/* tb/can_frame_to_slcan_ascii_tb.sv */
// Testbench for the CAN frame to slcan text line encoder: directed table, then random frames.
`timescale 1ns / 1ps

module can_frame_to_slcan_ascii_tb;

   localparam int N_CASES          = 22;
   localparam int RAND_PHASES      = 8;
   localparam int FRAMES_PER_PHASE = 49;

   // One received CAN frame, as presented on the req_* channel
   typedef struct packed {
      bit        ext;
      bit        rtr;
      bit [28:0] id;
      bit [3:0]  dlc;
      bit [63:0] data;
      bit [31:0] tick;
   } can_frame_type;

   // One character of the text line, as seen on the rsp_* channel
   typedef struct packed {
      logic [slcan_pkg::CHAR_W-1:0] ch;
      logic                         last;
   } text_char_type;

   // Directed row: timestamp setting, frame, and the line without its CR.
   // An empty line means the expected text comes from encode_line.
   typedef struct {
      bit            ts_en;
      can_frame_type frm;
      string         txt;
   } line_case_type;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_valid;
   logic                           req_ready;
   logic                           req_is_extended;
   logic                           req_is_remote;
   logic [28:0]                    req_frame_id;
   logic [3:0]                     req_length_code;
   logic [63:0]                    req_payload;
   logic [slcan_pkg::TICK_W-1:0]   req_tick_count;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [slcan_pkg::CHAR_W-1:0]   rsp_ascii_char;
   logic                           rsp_is_last;
   logic                           csr_valid;
   logic                           csr_ready;
   logic                           csr_timestamp_enable;

   // Local copy of the timestamp_enable register
   bit                  ts_model;
   // Characters still owed by the encoder, oldest first
   text_char_type       pending_text[$];
   line_case_type       line_cases[N_CASES];
   string               hex_glyphs = "0123456789ABCDEF";

   // Idle percentages for the sender (gaps) and the receiver (stalls)
   int                  gap_pct;
   int                  stall_pct;

   int                  err_count;
   int                  frames_sent;
   int                  stamped_frames;
   int                  chars_seen;
   int                  lines_seen;
   int                  csr_writes;

   can_frame_to_slcan_ascii uut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_is_extended      (req_is_extended),
      .req_is_remote        (req_is_remote),
      .req_frame_id         (req_frame_id),
      .req_length_code      (req_length_code),
      .req_payload          (req_payload),
      .req_tick_count       (req_tick_count),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_ascii_char       (rsp_ascii_char),
      .rsp_is_last          (rsp_is_last),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_timestamp_enable (csr_timestamp_enable)
   );

   // 12 ns period
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // Line encoder: builds the expected characters for one frame
   // ---------------------------------------------------------------

   function automatic void push_char(input logic [slcan_pkg::CHAR_W-1:0] c, input logic last);
      pending_text.push_back('{ch: c, last: last});
   endfunction

   // Upper-case hex, most significant digit first
   function automatic void push_hex(input bit [31:0] value, input int digits);
      byte g;
      for (int k = digits - 1; k >= 0; k--) begin
         g = hex_glyphs[value[4*k +: 4]];
         push_char(g[slcan_pkg::CHAR_W-1:0], 1'b0);
      end
   endfunction

   function automatic void encode_line(input can_frame_type f);
      bit [3:0]  n_bytes;
      bit [15:0] stamp;
      // DLC above 8 saturates; bytes past it are never sent
      n_bytes = (f.dlc > 4'd8) ? 4'd8 : f.dlc;
      if (f.ext) begin
         push_char(f.rtr ? slcan_pkg::CH_EXT_RT : slcan_pkg::CH_EXT_DT, 1'b0);
         push_hex({3'b000, f.id}, 8);
      end else begin
         // standard id: low 12 bits, whatever sits above bit 11
         push_char(f.rtr ? slcan_pkg::CH_STD_RT : slcan_pkg::CH_STD_DT, 1'b0);
         push_hex({20'h0, f.id[11:0]}, 3);
      end
      push_hex({28'h0, n_bytes}, 1);
      // remote frames carry their data bytes too
      for (int i = 0; i < n_bytes; i++)
         push_hex({24'h0, f.data[8*i +: 8]}, 2);
      if (ts_model) begin
         stamp = 16'(f.tick % 32'(slcan_pkg::TS_MODULUS));
         push_hex({16'h0, stamp}, 4);
      end
      push_char(slcan_pkg::CH_CR, 1'b1);
   endfunction

   function automatic can_frame_type random_frame();
      can_frame_type f;
      f.ext = 1'($urandom_range(1));
      f.rtr = 1'($urandom_range(1));
      case ($urandom_range(9))
         0:       f.id = '0;
         1:       f.id = '1;
         default: f.id = 29'($urandom);
      endcase
      // mostly legal DLCs, a quarter in the saturating range
      f.dlc  = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 9)) : 4'($urandom_range(8));
      f.data = {$urandom, $urandom};
      case ($urandom_range(7))
         // land on or just below a wrap of the timestamp
         0:       f.tick = 32'(slcan_pkg::TS_MODULUS) * $urandom_range(71583)
                           - $urandom_range(1);
         1:       f.tick = 32'hFFFF_FFFF - $urandom_range(3);
         default: f.tick = $urandom;
      endcase
      return f;
   endfunction

   function automatic void flag_mismatch(input string what, input longint unsigned want,
                                         input longint unsigned got);
      err_count++;
      $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
   endfunction

   // ---------------------------------------------------------------
   // Channel drivers (all driving at the falling edge)
   // ---------------------------------------------------------------

   // Hold the sender off until every owed character has come out.
   // The encoder is idle after the last CR transfer.
   task automatic drain_lines();
      req_valid <= 1'b0;
      @(negedge clock);
      while (pending_text.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_csr(input bit en);
      csr_timestamp_enable <= en;
      csr_valid            <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      ts_model = en;
      csr_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // One frame transfer; the expected line is queued at the accepting edge.
   // Valid stays up into the next call when no gap is rolled.
   task automatic send_frame(input can_frame_type f, input string fixed_txt);
      byte c;
      while ($urandom_range(99) < gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_is_extended <= f.ext;
      req_is_remote   <= f.rtr;
      req_frame_id    <= f.id;
      req_length_code <= f.dlc;
      req_payload     <= f.data;
      req_tick_count  <= f.tick;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!req_ready);
      frames_sent++;
      if (ts_model)
         stamped_frames++;
      if (fixed_txt.len() == 0) begin
         encode_line(f);
      end else begin
         for (int i = 0; i < fixed_txt.len(); i++) begin
            c = fixed_txt[i];
            push_char(c[slcan_pkg::CHAR_W-1:0], 1'b0);
         end
         push_char(slcan_pkg::CH_CR, 1'b1);
      end
      @(negedge clock);
   endtask

   // Receiver back-pressure, redrawn every cycle
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // ---------------------------------------------------------------
   // Result checker: every character transfer against the oldest owed one
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      text_char_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         chars_seen++;
         if (rsp_is_last)
            lines_seen++;
         if (pending_text.size() == 0) begin
            flag_mismatch("character with no line pending", 0, rsp_ascii_char);
         end else begin
            want = pending_text.pop_front();
            if (rsp_ascii_char !== want.ch)
               flag_mismatch("rsp_ascii_char", want.ch, rsp_ascii_char);
            if (rsp_is_last !== want.last)
               flag_mismatch("rsp_is_last", want.last, rsp_is_last);
         end
      end
   end

   // ---------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------
   initial begin
      // empty, all-ones and saturating frames with the text typed in;
      // the rest fall back on encode_line
      line_cases[0]  = '{1'b0, '{1'b0, 1'b0, 29'h0, 4'h0, 64'h0, 32'h0}, "t0000"};
      line_cases[1]  = '{1'b0, '{1'b0, 1'b1, 29'h7FF, 4'h8, 64'h0, 32'h0},
                         "r7FF80000000000000000"};
      line_cases[2]  = '{1'b0, '{1'b1, 1'b1, 29'h1FFF_FFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF,
                         32'hFFFF_FFFF}, "R1FFFFFFF8FFFFFFFFFFFFFFFF"};
      line_cases[3]  = '{1'b0, '{1'b1, 1'b0, 29'h0, 4'h0, 64'h0, 32'h0}, "T000000000"};
      // id bits above 11 dropped, unused bytes not sent
      line_cases[4]  = '{1'b0, '{1'b0, 1'b0, 29'h1FFF_FABC, 4'h2, 64'hFFFF_FFFF_FFFF_5AA5,
                         32'h0}, "tABC2A55A"};
      // byte 0 goes out first
      line_cases[5]  = '{1'b0, '{1'b0, 1'b0, 29'h123, 4'h9, 64'h0123_4567_89AB_CDEF, 32'h0},
                         "t1238EFCDAB8967452301"};
      line_cases[6]  = '{1'b0, '{1'b1, 1'b0, 29'h0ABC_DEF0, 4'h1, 64'hDEAD_BEEF_CAFE_F00D,
                         32'h1234}, ""};
      line_cases[7]  = '{1'b0, '{1'b0, 1'b1, 29'h456, 4'h3, 64'h0011_2233_4455_6677,
                         32'h0}, ""};
      line_cases[8]  = '{1'b0, '{1'b1, 1'b0, 29'h1000_0000, 4'h4, 64'h8899_AABB_CCDD_EEFF,
                         32'h0}, ""};
      line_cases[9]  = '{1'b0, '{1'b0, 1'b0, 29'h7FF, 4'h5, 64'hA5A5_5A5A_0F0F_F0F0,
                         32'h0}, ""};
      line_cases[10] = '{1'b0, '{1'b1, 1'b1, 29'h1, 4'h6, 64'h1357_9BDF_2468_ACE0,
                         32'h0}, ""};
      line_cases[11] = '{1'b0, '{1'b0, 1'b0, 29'h800, 4'h7, 64'hFEDC_BA98_7654_3210,
                         32'h0}, ""};
      line_cases[12] = '{1'b0, '{1'b0, 1'b0, 29'h0, 4'hC, 64'h0102_0408_1020_4080,
                         32'h0}, ""};
      // timestamp on: zero, exact wrap, one below the wrap
      line_cases[13] = '{1'b1, '{1'b0, 1'b0, 29'h0, 4'h0, 64'h0, 32'd0}, "t00000000"};
      line_cases[14] = '{1'b1, '{1'b0, 1'b0, 29'h0, 4'h0, 64'h0, 32'd59999}, "t00000000"};
      line_cases[15] = '{1'b1, '{1'b0, 1'b0, 29'h0, 4'h0, 64'h0, 32'd59998}, "t0000EA5E"};
      line_cases[16] = '{1'b1, '{1'b0, 1'b0, 29'h0, 4'h0, 64'h0, 32'hFFFF_FFFF}, ""};
      // longest possible line, 31 characters
      line_cases[17] = '{1'b1, '{1'b1, 1'b1, 29'h1FFF_FFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF,
                         32'hFFFF_FFFF}, ""};
      line_cases[18] = '{1'b1, '{1'b0, 1'b0, 29'h0, 4'h1, 64'h0, 32'd119998}, ""};
      line_cases[19] = '{1'b1, '{1'b1, 1'b0, 29'hABCD, 4'h8, 64'h0, 32'd60000}, ""};
      line_cases[20] = '{1'b1, '{1'b0, 1'b1, 29'h1, 4'hF, 64'h7766_5544_3322_1100,
                         32'd119997}, ""};
      line_cases[21] = '{1'b0, '{1'b0, 1'b0, 29'h5A5, 4'h8, 64'hC3C3_3C3C_9696_6969,
                         32'h0}, ""};

      reset                = 1'b1;
      req_valid            = 1'b0;
      req_is_extended      = 1'b0;
      req_is_remote        = 1'b0;
      req_frame_id         = '0;
      req_length_code      = '0;
      req_payload          = '0;
      req_tick_count       = '0;
      rsp_ready            = 1'b0;
      csr_valid            = 1'b0;
      csr_timestamp_enable = 1'b0;
      gap_pct              = 0;
      stall_pct            = 0;
      ts_model             = 1'b0;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table, no idling; register only touched when idle
      write_csr(1'b0);
      for (int r = 0; r < N_CASES; r++) begin
         if (line_cases[r].ts_en != ts_model) begin
            drain_lines();
            write_csr(line_cases[r].ts_en);
         end
         send_frame(line_cases[r].frm, line_cases[r].txt);
      end

      // random phases: each idle mode once with the timestamp off, once on
      for (int p = 0; p < RAND_PHASES; p++) begin
         drain_lines();
         case (p % 4)
            0: begin gap_pct = 0;  stall_pct = 0;  end
            1: begin gap_pct = 69; stall_pct = 0;  end
            2: begin gap_pct = 0;  stall_pct = 69; end
            default: begin gap_pct = 16; stall_pct = 16; end
         endcase
         write_csr(p >= RAND_PHASES / 2);
         for (int k = 0; k < FRAMES_PER_PHASE; k++) begin
            // now and then let the encoder run completely dry
            if ($urandom_range(49) == 0)
               drain_lines();
            send_frame(random_frame(), "");
         end
      end

      // everything owed, then a quiet stretch to catch stray characters
      drain_lines();
      repeat (80) @(negedge clock);
      if (pending_text.size() != 0)
         flag_mismatch("characters still owed", 0, pending_text.size());

      $display("covered %0d frames (%0d with timestamps), %0d characters, %0d lines",
               frames_sent, stamped_frames, chars_seen, lines_seen);
      $display("%0d register writes, idle modes none/sender/receiver/both, %0d mismatches",
               csr_writes, err_count);
      if (err_count == 0)
         $display("can_frame_to_slcan_ascii_tb: clean");
      else
         $display("can_frame_to_slcan_ascii_tb: errors");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run
   initial begin
      #20_000_000;
      $display("%0t ns: timed out, %0d characters still owed", $time, pending_text.size());
      $display("can_frame_to_slcan_ascii_tb: errors");
      $finish;
   end

endmodule
